### sv/lr_pkg.sv
// Package for the line rasterizer: tile constants, coordinate clamp and the
// command/status structs passed between controller and datapath.
// No dependencies.
`default_nettype none

package lr_pkg;

  localparam int TILE_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam int ERR_W     = COORD_W + 4;
  localparam logic [COORD_W-1:0] TILE_MAX = COORD_W'(TILE_SIZE - 1);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture endpoints
    logic setup;  // derive deltas, directions and initial error
    logic step;   // advance to next pixel
  } lr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;   // current pixel is the final one
  } lr_sts_t;

  function automatic coord_t clamp_coord(input coord_t c);
    clamp_coord = (c > TILE_MAX) ? TILE_MAX : c;
  endfunction

endpackage

`default_nettype wire

### sv/lr_datapath.sv
// Line rasterizer datapath: endpoint registers, Bresenham error term,
// current pixel position and remaining-step counter.
// Depends on lr_pkg.
`default_nettype none

module lr_datapath
  import lr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire lr_cmd_t cmd_i,
  output lr_sts_t      sts_o,
  input  wire coord_t  start_x_i,
  input  wire coord_t  start_y_i,
  input  wire coord_t  end_x_i,
  input  wire coord_t  end_y_i,
  output coord_t       pixel_x_o,
  output coord_t       pixel_y_o,
  output logic         last_pixel_o
);

  coord_t x_q, x_d, y_q, y_d;
  coord_t xe_q, ye_q;
  coord_t major_q, major_d, minor_q, minor_d;
  coord_t cnt_q, cnt_d;
  err_t   err_q, err_d;
  logic   x_major_q, x_major_d;
  logic   x_inc_q, x_inc_d, y_inc_q, y_inc_d;

  logic signed [COORD_W:0] dx, dy;
  coord_t ax, ay;
  logic   err_ge;
  err_t   minor2, major2;

  assign dx = $signed({1'b0, xe_q}) - $signed({1'b0, x_q});
  assign dy = $signed({1'b0, ye_q}) - $signed({1'b0, y_q});
  assign ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

  assign minor2 = $signed({{(ERR_W-COORD_W-1){1'b0}}, minor_q, 1'b0});
  assign major2 = $signed({{(ERR_W-COORD_W-1){1'b0}}, major_q, 1'b0});
  assign err_ge = ~err_q[ERR_W-1];

  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    major_d   = major_q;
    minor_d   = minor_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    x_major_d = x_major_q;
    x_inc_d   = x_inc_q;
    y_inc_d   = y_inc_q;
    if (cmd_i.load) begin
      x_d = clamp_coord(start_x_i);
      y_d = clamp_coord(start_y_i);
    end else if (cmd_i.setup) begin
      x_major_d = (ax >= ay);
      major_d   = (ax >= ay) ? ax : ay;
      minor_d   = (ax >= ay) ? ay : ax;
      x_inc_d   = ~dx[COORD_W];
      y_inc_d   = ~dy[COORD_W];
      cnt_d     = major_d;
      err_d     = $signed({{(ERR_W-COORD_W-1){1'b0}}, minor_d, 1'b0})
                - $signed({{(ERR_W-COORD_W){1'b0}}, major_d});
    end else if (cmd_i.step) begin
      // major axis always moves; minor axis moves on a non-negative error
      if (x_major_q || err_ge) begin
        x_d = x_inc_q ? x_q + COORD_W'(1) : x_q - COORD_W'(1);
      end
      if (!x_major_q || err_ge) begin
        y_d = y_inc_q ? y_q + COORD_W'(1) : y_q - COORD_W'(1);
      end
      err_d = err_q + minor2 - (err_ge ? major2 : err_t'(0));
      cnt_d = cnt_q - COORD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xe_q      <= '0;
      ye_q      <= '0;
      x_q       <= '0;
      y_q       <= '0;
      major_q   <= '0;
      minor_q   <= '0;
      cnt_q     <= '0;
      err_q     <= '0;
      x_major_q <= 1'b0;
      x_inc_q   <= 1'b0;
      y_inc_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        xe_q <= clamp_coord(end_x_i);
        ye_q <= clamp_coord(end_y_i);
      end
      x_q       <= x_d;
      y_q       <= y_d;
      major_q   <= major_d;
      minor_q   <= minor_d;
      cnt_q     <= cnt_d;
      err_q     <= err_d;
      x_major_q <= x_major_d;
      x_inc_q   <= x_inc_d;
      y_inc_q   <= y_inc_d;
    end
  end

  assign sts_o.last   = (cnt_q == '0);
  assign pixel_x_o    = x_q;
  assign pixel_y_o    = y_q;
  assign last_pixel_o = sts_o.last;

endmodule

`default_nettype wire

### sv/lr_ctrl.sv
// Line rasterizer controller: accepts a segment, sequences setup and the
// per-pixel stepping, and drives both handshakes.
// Depends on lr_pkg.
`default_nettype none

module lr_ctrl
  import lr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  input  wire lr_sts_t sts_i,
  output lr_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_take;

  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d     = ST_EMIT;
        out_valid_d = 1'b1;
      end
      ST_EMIT: begin
        if (out_take && sts_i.last) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b0;
        end
      end
      default: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load  = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.setup = (state_q == ST_SETUP);
  assign cmd_o.step  = (state_q == ST_EMIT) && out_take && !sts_i.last;

endmodule

`default_nettype wire

### sv/line_rasterizer_top.sv
// Channel  | dir | handshake                  | words
// ---------+-----+----------------------------+-----------------------------------
// segment  | in  | in_valid_i / in_stall_o    | start_x_i start_y_i end_x_i end_y_i
// pixel    | out | out_valid_o / out_stall_i  | pixel_x_o pixel_y_o last_pixel_o
//
// One segment at a time: accept, a setup state, then one pixel word per
// cycle while out_stall_i is low, max(|dx|,|dy|)+1 words (1..64) per segment.
// The single-step error/position loop in lr_datapath sets that rate.
// Output stall freezes the current pixel; input is stalled until the last
// word of the segment is taken. Reset (async, active low) returns to idle.
// Depends on lr_pkg, lr_ctrl, lr_datapath.
`default_nettype none

module line_rasterizer_top
  import lr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_stall_o,
  input  wire coord_t start_x_i,
  input  wire coord_t start_y_i,
  input  wire coord_t end_x_i,
  input  wire coord_t end_y_i,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output coord_t      pixel_x_o,
  output coord_t      pixel_y_o,
  output logic        last_pixel_o
);

  lr_cmd_t cmd;
  lr_sts_t sts;

  lr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

`default_nettype wire

### sv/lr_checker.sv
// Port-level checks for line_rasterizer_top, attached by bind.
// Depends on lr_pkg.
`default_nettype none

module lr_checker
  import lr_pkg::*;
(
  input wire logic   clk_i,
  input wire logic   rst_ni,
  input wire logic   in_valid_i,
  input wire logic   in_stall_o,
  input wire logic   out_valid_o,
  input wire logic   out_stall_i,
  input wire coord_t pixel_x_o,
  input wire coord_t pixel_y_o,
  input wire logic   last_pixel_o
);

  logic out_take;
  assign out_take = out_valid_o && !out_stall_i;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_x_o)
      && $stable(pixel_y_o) && $stable(last_pixel_o))
    else $error("stalled pixel word changed");

  // a taken segment blocks further input next cycle
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after segment accept");

  // no pixel output while idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("pixel output while idle");

  // segment ends after the marked pixel
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && last_pixel_o |=> !out_valid_o)
    else $error("output continues after last pixel");

  // successive pixels of a segment are 8-neighbors
  a_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !last_pixel_o |=> out_valid_o
      && (pixel_x_o == $past(pixel_x_o) || pixel_x_o == $past(pixel_x_o) + 6'd1
          || pixel_x_o == $past(pixel_x_o) - 6'd1)
      && (pixel_y_o == $past(pixel_y_o) || pixel_y_o == $past(pixel_y_o) + 6'd1
          || pixel_y_o == $past(pixel_y_o) - 6'd1)
      && !(pixel_x_o == $past(pixel_x_o) && pixel_y_o == $past(pixel_y_o)))
    else $error("pixel step is not to a neighbor");

endmodule

bind line_rasterizer_top lr_checker u_lr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pixel_x_o    (pixel_x_o),
  .pixel_y_o    (pixel_y_o),
  .last_pixel_o (last_pixel_o)
);

`default_nettype wire
